[sv/bpa_pkg.sv]
// Shared types, codes and constants of the bitmap pixel access unit.
`default_nettype none

package bpa_pkg;

  // Default storage sizes
  localparam int FRAME_BYTES_DEFAULT     = 262144;
  localparam int PALETTE_ENTRIES_DEFAULT = 256;

  // Datapath widths
  localparam int CFG_DW = 15;
  localparam int BASE_W = 28;
  localparam int OFFS_W = 14;
  localparam int ADDR_W = 29;

  // Indexes below this fit a 4 bpp nibble
  localparam logic [7:0] NIBBLE_LIMIT = 8'd16;
  localparam logic [7:0] NIB_HI_MASK  = 8'hF0;
  localparam logic [7:0] NIB_LO_MASK  = 8'h0F;

  // Request kinds
  localparam logic [2:0] KIND_GET_RGB   = 3'd0;
  localparam logic [2:0] KIND_SET_RGB   = 3'd1;
  localparam logic [2:0] KIND_GET_INDEX = 3'd2;
  localparam logic [2:0] KIND_SET_INDEX = 3'd3;
  localparam logic [2:0] KIND_GET_PAL   = 3'd4;
  localparam logic [2:0] KIND_SET_PAL   = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Pixel depth modes
  localparam logic [1:0] MODE_4BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd1;
  localparam logic [1:0] MODE_24BPP = 2'd2;
  localparam logic [1:0] MODE_32BPP = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_STRIDE = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  color_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] index_out;
  } out_item_t;

  typedef enum logic [1:0] {
    FOP_NONE,
    FOP_READ,
    FOP_WRITE
  } fop_t;

  typedef enum logic [1:0] {
    POP_NONE,
    POP_READ_CI,
    POP_READ_IDX,
    POP_WRITE
  } pop_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_BLUE,
    CAP_GREEN,
    CAP_RED,
    CAP_INDEX,
    CAP_PAL
  } cap_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       calc;
    logic       addr;
    logic       check;
    fop_t       fop;
    logic [1:0] fsel;
    pop_t       pop;
    cap_t       cap;
    logic       publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clear_last;
    logic       err;
    logic [2:0] kind;
    logic [1:0] mode;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/bpa_ctrl.sv]
// Sequencing state machine of the bitmap pixel access unit.
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_ADDR,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_WR0,
    S_WR1,
    S_WR2,
    S_IRD,
    S_IUSE,
    S_PRD,
    S_PCAP,
    S_PWR,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   indexed;

  assign indexed  = (sts.mode == MODE_4BPP) || (sts.mode == MODE_8BPP);
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.clear   = 1'b0;
    cmd.load    = 1'b0;
    cmd.calc    = 1'b0;
    cmd.addr    = 1'b0;
    cmd.check   = 1'b0;
    cmd.fop     = FOP_NONE;
    cmd.fsel    = 2'd0;
    cmd.pop     = POP_NONE;
    cmd.cap     = CAP_NONE;
    cmd.publish = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.err) begin
          state_nxt = S_DONE;
        end else begin
          case (sts.kind)
            KIND_GET_RGB:   state_nxt = indexed ? S_IRD : S_RD0;
            KIND_SET_RGB:   state_nxt = S_WR0;
            KIND_GET_INDEX: state_nxt = S_IRD;
            KIND_SET_INDEX: state_nxt = (sts.mode == MODE_8BPP) ? S_WR0 : S_IRD;
            KIND_GET_PAL:   state_nxt = S_PRD;
            KIND_SET_PAL:   state_nxt = S_PWR;
            default:        state_nxt = S_DONE;
          endcase
        end
      end
      // Frame reads are registered: capture one step behind the address
      S_RD0: begin
        cmd.fop   = FOP_READ;
        cmd.fsel  = 2'd0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.fop   = FOP_READ;
        cmd.fsel  = 2'd1;
        cmd.cap   = CAP_BLUE;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.fop   = FOP_READ;
        cmd.fsel  = 2'd2;
        cmd.cap   = CAP_GREEN;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        cmd.cap   = CAP_RED;
        state_nxt = S_DONE;
      end
      S_WR0: begin
        cmd.fop   = FOP_WRITE;
        cmd.fsel  = 2'd0;
        state_nxt = (sts.kind == KIND_SET_RGB) ? S_WR1 : S_DONE;
      end
      S_WR1: begin
        cmd.fop   = FOP_WRITE;
        cmd.fsel  = 2'd1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.fop   = FOP_WRITE;
        cmd.fsel  = 2'd2;
        state_nxt = S_DONE;
      end
      S_IRD: begin
        cmd.fop   = FOP_READ;
        cmd.fsel  = 2'd0;
        state_nxt = S_IUSE;
      end
      S_IUSE: begin
        case (sts.kind)
          KIND_GET_RGB: begin
            cmd.pop   = POP_READ_IDX;
            state_nxt = S_PCAP;
          end
          KIND_GET_INDEX: begin
            cmd.cap   = CAP_INDEX;
            state_nxt = S_DONE;
          end
          default: begin
            // 4 bpp set index: write back the merged byte
            cmd.fop   = FOP_WRITE;
            cmd.fsel  = 2'd0;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_PRD: begin
        cmd.pop   = POP_READ_CI;
        state_nxt = S_PCAP;
      end
      S_PCAP: begin
        cmd.cap   = CAP_PAL;
        state_nxt = S_DONE;
      end
      S_PWR: begin
        cmd.pop   = POP_WRITE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/bpa_datapath.sv]
// Registers, address arithmetic, frame and palette memories and result register.
`default_nettype none

module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int FRAME_BYTES     = FRAME_BYTES_DEFAULT,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
  input  wire                clk,
  input  wire                rst_n,
  input  in_item_t           in_data,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [CFG_DW-1:0]  cfg_wdata,
  input  wire                out_stall,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  output out_item_t          out_data
);

  localparam int FAW       = $clog2(FRAME_BYTES);
  localparam int PAW       = $clog2(PALETTE_ENTRIES);
  localparam int CLEAR_LEN = (FRAME_BYTES > PALETTE_ENTRIES) ? FRAME_BYTES : PALETTE_ENTRIES;
  localparam int CW        = $clog2(CLEAR_LEN);

  localparam logic [CW:0]     FB_CLR_LIM = (CW+1)'(FRAME_BYTES);
  localparam logic [CW:0]     PE_CLR_LIM = (CW+1)'(PALETTE_ENTRIES);
  localparam logic [CW-1:0]   CLR_LAST   = CW'(CLEAR_LEN - 1);
  localparam logic [ADDR_W-1:0] FB_LIM   = ADDR_W'(FRAME_BYTES);
  localparam logic [8:0]      PE_LIM     = 9'(PALETTE_ENTRIES);

  // Configuration
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  mode_r;
  logic [14:0] stride_r;

  // Request and working registers
  in_item_t          req_r;
  logic [BASE_W-1:0] base_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] end_r;
  logic [1:0]        st_r;
  logic [7:0]        res_red_r;
  logic [7:0]        res_green_r;
  logic [7:0]        res_blue_r;
  logic [7:0]        res_idx_r;
  logic [CW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Memories and their read registers
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [23:0] pal_mem   [PALETTE_ENTRIES];
  logic [7:0]  frame_q_r;
  logic [23:0] pal_q_r;

  logic              indexed;
  logic              coords_ok;
  logic              nib_bad;
  logic              ci_bad;
  logic [1:0]        st_calc;
  logic [12:0]       row_c;
  logic [BASE_W-1:0] base_c;
  logic [OFFS_W-1:0] offs_c;
  logic [ADDR_W-1:0] addr_c;
  logic [ADDR_W-1:0] end_c;
  logic              range_bad;
  logic [7:0]        idx_c;
  logic              idx_bad;
  logic [ADDR_W-1:0] acc_addr;
  logic [7:0]        merged_c;
  logic [7:0]        fw_data_c;
  logic              f_we;
  logic [FAW-1:0]    f_addr;
  logic [7:0]        f_wdata;
  logic              p_we;
  logic [PAW-1:0]    p_addr;
  logic [23:0]       p_wdata;
  logic              out_free;

  assign indexed   = (mode_r == MODE_4BPP) || (mode_r == MODE_8BPP);
  assign coords_ok = ({1'b0, req_r.pos_x} < width_r) && ({1'b0, req_r.pos_y} < height_r);
  assign nib_bad   = (mode_r == MODE_4BPP) && (req_r.color_index >= NIBBLE_LIMIT);
  assign ci_bad    = ({1'b0, req_r.color_index} >= PE_LIM);

  // Early checks, in the order the kinds define them
  always_comb begin
    st_calc = ST_OK;
    case (req_r.kind)
      KIND_GET_RGB: begin
        if (!coords_ok) st_calc = ST_INVALID;
      end
      KIND_SET_RGB: begin
        if (!coords_ok)   st_calc = ST_INVALID;
        else if (indexed) st_calc = ST_MISMATCH;
      end
      KIND_GET_INDEX: begin
        if (!coords_ok)    st_calc = ST_INVALID;
        else if (!indexed) st_calc = ST_MISMATCH;
      end
      KIND_SET_INDEX: begin
        if (!coords_ok || nib_bad) st_calc = ST_INVALID;
        else if (!indexed)         st_calc = ST_MISMATCH;
      end
      KIND_GET_PAL, KIND_SET_PAL: begin
        if (nib_bad)       st_calc = ST_INVALID;
        else if (!indexed) st_calc = ST_MISMATCH;
        else if (ci_bad)   st_calc = ST_INVALID;
      end
      default: st_calc = ST_INVALID;
    endcase
  end

  // Rows are stored bottom-up
  assign row_c  = height_r - {1'b0, req_r.pos_y} - 13'd1;
  assign base_c = {15'd0, row_c} * {13'd0, stride_r};

  always_comb begin
    case (mode_r)
      MODE_4BPP:  offs_c = {3'd0, req_r.pos_x[11:1]};
      MODE_8BPP:  offs_c = {2'd0, req_r.pos_x};
      MODE_24BPP: offs_c = {1'b0, req_r.pos_x, 1'b0} + {2'd0, req_r.pos_x};
      default:    offs_c = {req_r.pos_x, 2'd0};
    endcase
  end

  assign addr_c    = {1'b0, base_r} + {{(ADDR_W-OFFS_W){1'b0}}, offs_c};
  assign end_c     = addr_c + (indexed ? ADDR_W'(0) : ADDR_W'(2));
  assign range_bad = (req_r.kind <= KIND_SET_INDEX) && (end_r >= FB_LIM);

  // Colour index from the byte just read
  always_comb begin
    if (mode_r == MODE_8BPP) begin
      idx_c = frame_q_r;
    end else if (!req_r.pos_x[0]) begin
      idx_c = (frame_q_r & NIB_HI_MASK) >> 4;
    end else begin
      idx_c = frame_q_r & NIB_LO_MASK;
    end
  end
  assign idx_bad = ({1'b0, idx_c} >= PE_LIM);

  always_comb begin
    if (!req_r.pos_x[0]) begin
      merged_c = (frame_q_r & NIB_LO_MASK) | {req_r.color_index[3:0], 4'd0};
    end else begin
      merged_c = (frame_q_r & NIB_HI_MASK) | (req_r.color_index & NIB_LO_MASK);
    end
  end

  // Bytes of a direct-colour pixel go out B, G, R
  always_comb begin
    if (req_r.kind == KIND_SET_RGB) begin
      case (cmd.fsel)
        2'd0:    fw_data_c = req_r.blue_in;
        2'd1:    fw_data_c = req_r.green_in;
        default: fw_data_c = req_r.red_in;
      endcase
    end else if (mode_r == MODE_4BPP) begin
      fw_data_c = merged_c;
    end else begin
      fw_data_c = req_r.color_index;
    end
  end

  assign acc_addr = addr_r + {{(ADDR_W-2){1'b0}}, cmd.fsel};

  assign f_we    = cmd.clear ? ({1'b0, clr_cnt_r} < FB_CLR_LIM) : (cmd.fop == FOP_WRITE);
  assign f_addr  = cmd.clear ? clr_cnt_r[FAW-1:0] : acc_addr[FAW-1:0];
  assign f_wdata = cmd.clear ? 8'd0 : fw_data_c;

  assign p_we    = cmd.clear ? ({1'b0, clr_cnt_r} < PE_CLR_LIM) : (cmd.pop == POP_WRITE);
  assign p_wdata = cmd.clear ? 24'd0 : {req_r.red_in, req_r.green_in, req_r.blue_in};

  always_comb begin
    if (cmd.clear) begin
      p_addr = clr_cnt_r[PAW-1:0];
    end else if (cmd.pop == POP_READ_IDX) begin
      p_addr = idx_c[PAW-1:0];
    end else begin
      p_addr = req_r.color_index[PAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) frame_mem[f_addr] <= f_wdata;
    frame_q_r <= frame_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (p_we) pal_mem[p_addr] <= p_wdata;
    pal_q_r <= pal_mem[p_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1;
      height_r <= 13'd1;
      mode_r   <= MODE_24BPP;
      stride_r <= 15'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[12:0];
        REG_HEIGHT: height_r <= cfg_wdata[12:0];
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_STRIDE: stride_r <= cfg_wdata[14:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + CW'(1);
    end
  end

  // Request processing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_data;
      res_red_r   <= 8'd0;
      res_green_r <= 8'd0;
      res_blue_r  <= 8'd0;
      res_idx_r   <= 8'd0;
    end
    if (cmd.calc) begin
      st_r   <= st_calc;
      base_r <= base_c;
    end
    if (cmd.addr) begin
      addr_r <= addr_c;
      end_r  <= end_c;
    end
    if (cmd.check && range_bad && (st_r == ST_OK)) begin
      st_r <= ST_INVALID;
    end
    if ((cmd.pop == POP_READ_IDX) && idx_bad) begin
      st_r <= ST_INVALID;
    end
    case (cmd.cap)
      CAP_BLUE:  res_blue_r  <= frame_q_r;
      CAP_GREEN: res_green_r <= frame_q_r;
      CAP_RED:   res_red_r   <= frame_q_r;
      CAP_INDEX: res_idx_r   <= idx_c;
      CAP_PAL: begin
        res_red_r   <= pal_q_r[23:16];
        res_green_r <= pal_q_r[15:8];
        res_blue_r  <= pal_q_r[7:0];
      end
      default: ;
    endcase
  end

  // Output register: frees once its transfer completes
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.status <= st_r;
      if (st_r == ST_OK) begin
        out_data_r.red_out   <= res_red_r;
        out_data_r.green_out <= res_green_r;
        out_data_r.blue_out  <= res_blue_r;
        out_data_r.index_out <= res_idx_r;
      end else begin
        out_data_r.red_out   <= 8'd0;
        out_data_r.green_out <= 8'd0;
        out_data_r.blue_out  <= 8'd0;
        out_data_r.index_out <= 8'd0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clear_last = (clr_cnt_r == CLR_LAST);
  assign sts.err        = (st_r != ST_OK) || range_bad;
  assign sts.kind       = req_r.kind;
  assign sts.mode       = mode_r;
  assign sts.out_free   = out_free;

endmodule

`default_nettype wire

[sv/bitmap_pixel_access_unit.sv]
// Top level of the bitmap pixel access unit: controller and datapath.
//
//   port group | direction | handshake            | payload
//   in_        | input     | in_valid / in_stall   | in_data (in_item_t)
//   out_       | output    | out_valid / out_stall | out_data (out_item_t)
//   cfg_       | input     | cfg_we                | cfg_index, cfg_wdata
//
// One request at a time, in steps: three for checks, the row-base multiply and
// the bound test, up to four steps on the single-port byte-wide frame memory
// or the palette (none for a rejected request), one to load the output register
// and one back in idle. After reset a clearing pass zeroes both stores, one
// entry a cycle, over max(FRAME_BYTES, PALETTE_ENTRIES) entries (262144 by
// default); in_stall is high.
// A stalled result holds the next one in the result step until the transfer.
`default_nettype none

module bitmap_pixel_access_unit
  import bpa_pkg::*;
#(
  parameter int FRAME_BYTES     = FRAME_BYTES_DEFAULT,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output out_item_t         out_data,
  input  wire               cfg_we,
  input  wire  [1:0]        cfg_index,
  input  wire  [CFG_DW-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .FRAME_BYTES     (FRAME_BYTES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sv/bpa_checker.sv]
// Port-level assertions for the bitmap pixel access unit, bound to the top level.
`default_nettype none

module bpa_checker
  import bpa_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input out_item_t out_data
);

  // Clearing pass holds the input off straight after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_stall)
    else $error("input not stalled after reset");

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.red_out == 8'd0) && (out_data.green_out == 8'd0) &&
      (out_data.blue_out == 8'd0) && (out_data.index_out == 8'd0))
    else $error("error result carries data");

  // An index result never carries a colour
  a_index_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.index_out != 8'd0) |->
      (out_data.red_out == 8'd0) && (out_data.green_out == 8'd0) &&
      (out_data.blue_out == 8'd0))
    else $error("index and colour in one result");

endmodule

bind bitmap_pixel_access_unit bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
